// File: hw/rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Types and constants for the indexed list core: sizes, op codes, sequencer
// state, job descriptor and memory request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilid_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 16;
  localparam int POS_W    = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_UP   = 2'd1,
    JOB_DOWN = 2'd2,
    JOB_READ = 2'd3
  } job_kind_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_STEP = 2'd1,
    S_MOVE = 2'd2,
    S_FIN  = 2'd3
  } seq_state_t;

  typedef struct packed {
    job_kind_t           kind;
    logic [ADDR_W-1:0]   ptr;
    logic [ADDR_W-1:0]   stop;
    logic [DATA_W-1:0]   val;
  } job_t;

  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [DATA_W-1:0]   wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// File: hw/rtl/ilid_mem.sv
// ----------------------------------------------------------------------------
// ilid_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilid_mem (
  input  wire logic                          clk,
  input  wire ilid_pkg::mem_req_t            req,
  output logic [ilid_pkg::DATA_W-1:0]        rd_data_r
);

  logic [ilid_pkg::DATA_W-1:0] mem_r [ilid_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem_r[req.raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ilid_ctrl.sv
// ----------------------------------------------------------------------------
// ilid_ctrl
// Shift sequencer: walks a pointer through the store entry by entry, moving
// entries up or down, then finishes; an insert ends with its write there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilid_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  input  wire ilid_pkg::job_t                  job,
  input  wire logic [ilid_pkg::DATA_W-1:0]     rd_data,
  input  wire logic                            out_free,
  output ilid_pkg::mem_req_t                   mem_req,
  output logic                                 busy,
  output logic                                 finish
);

  ilid_pkg::seq_state_t              state_r, state_nxt;
  ilid_pkg::job_kind_t               kind_r;
  logic [ilid_pkg::ADDR_W-1:0]       ptr_r, ptr_nxt;
  logic [ilid_pkg::ADDR_W-1:0]       stop_r;
  logic [ilid_pkg::DATA_W-1:0]       val_r;
  logic [ilid_pkg::ADDR_W-1:0]       src;
  logic                              at_stop;

  // shared step unit: neighbour address and end compare
  assign src     = (kind_r == ilid_pkg::JOB_UP) ? ptr_r - 1'b1 : ptr_r + 1'b1;
  assign at_stop = (ptr_r == stop_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ilid_pkg::S_IDLE: begin
        if (start) begin
          if (job.kind == ilid_pkg::JOB_UP || job.kind == ilid_pkg::JOB_DOWN) begin
            state_nxt = ilid_pkg::S_STEP;
          end else begin
            state_nxt = ilid_pkg::S_FIN;
          end
        end
      end
      ilid_pkg::S_STEP: state_nxt = at_stop ? ilid_pkg::S_FIN : ilid_pkg::S_MOVE;
      ilid_pkg::S_MOVE: state_nxt = ilid_pkg::S_STEP;
      ilid_pkg::S_FIN:  state_nxt = out_free ? ilid_pkg::S_IDLE : ilid_pkg::S_FIN;
      default:          state_nxt = ilid_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_req = '0;
    ptr_nxt = ptr_r;
    busy    = 1'b1;
    finish  = 1'b0;
    unique case (state_r)
      ilid_pkg::S_IDLE: begin
        busy          = 1'b0;
        mem_req.re    = start && (job.kind == ilid_pkg::JOB_READ);
        mem_req.raddr = job.ptr;
      end
      ilid_pkg::S_STEP: begin
        mem_req.re    = !at_stop;
        mem_req.raddr = src;
      end
      ilid_pkg::S_MOVE: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr_r;
        mem_req.wdata = rd_data;
        ptr_nxt       = src;
      end
      ilid_pkg::S_FIN: begin
        mem_req.we    = (kind_r == ilid_pkg::JOB_UP);
        mem_req.waddr = ptr_r;
        mem_req.wdata = val_r;
        finish        = out_free;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ilid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ilid_pkg::S_IDLE && start) begin
      kind_r <= job.kind;
      ptr_r  <= job.ptr;
      stop_r <= job.stop;
      val_r  <= job.val;
    end else begin
      ptr_r  <= ptr_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/indexed_list_insert_delete_core.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core
// Ordered list of signed 32-bit entries with insert and delete at a clamped
// index and read with a range check; entries held in a store with one write
// and one read port and shifted by a small sequencer.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_ready    in_op, in_value, in_index
//   out_     out  out_valid/out_ready  out_position, out_entry_value,
//                                      out_entry_count, out_dropped,
//                                      out_out_of_range
//
// An insert at position p into n entries moves n-p entries and a delete at p
// moves n-1-p; each moved entry costs one read and one write of the store.
// Reset clears the count and control; the store is not cleared.
// in_ready is low while an item is being worked on; a held result waits in
// the output register and the next item may be accepted meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_insert_delete_core (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [1:0]            in_op,
  input  wire logic signed [31:0]    in_value,
  input  wire logic signed [15:0]    in_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [7:0]          out_position,
  output logic signed [31:0]         out_entry_value,
  output logic [6:0]                 out_entry_count,
  output logic                       out_dropped,
  output logic                       out_out_of_range
);

  localparam int CW = ilid_pkg::CNT_W;
  localparam int AW = ilid_pkg::ADDR_W;
  localparam int PW = ilid_pkg::POS_W;

  logic [CW-1:0]              count_r, count_nxt;
  logic signed [PW-1:0]       res_pos_r, pos_nxt;
  logic                       res_drop_r, drop_nxt;
  logic                       res_oor_r, oor_nxt;
  logic                       res_rd_r, rd_nxt;

  logic                       out_valid_r;
  logic signed [PW-1:0]       out_position_r;
  logic [ilid_pkg::DATA_W-1:0] out_entry_value_r;
  logic [CW-1:0]              out_entry_count_r;
  logic                       out_dropped_r;
  logic                       out_oor_r;

  ilid_pkg::job_t             job;
  ilid_pkg::mem_req_t         mem_req;
  logic [ilid_pkg::DATA_W-1:0] rd_data;
  logic                       busy, finish, out_free, accept;

  logic                       idx_le0, idx_ge_cnt, idx_ge_last, full;
  logic [AW-1:0]              idx_lo, cnt_lo, last_lo;

  assign accept   = in_valid && in_ready;
  assign in_ready = !busy;
  assign out_free = !out_valid_r || out_ready;

  assign idx_le0     = in_index[15] || (in_index == '0);
  assign idx_ge_cnt  = !in_index[15] && (in_index[14:0] >= 15'(count_r));
  assign idx_ge_last = (count_r == '0) ||
                       (!in_index[15] && (in_index[14:0] >= 15'(count_r - 1'b1)));
  assign full        = (count_r == CW'(ilid_pkg::CAPACITY));
  assign idx_lo      = in_index[AW-1:0];
  assign cnt_lo      = count_r[AW-1:0];
  assign last_lo     = AW'(count_r - 1'b1);

  always_comb begin
    job       = '0;
    job.kind  = ilid_pkg::JOB_NONE;
    job.val   = in_value;
    count_nxt = count_r;
    pos_nxt   = '0;
    drop_nxt  = 1'b0;
    oor_nxt   = 1'b0;
    rd_nxt    = 1'b0;
    unique case (ilid_pkg::op_t'(in_op))
      ilid_pkg::OP_INSERT: begin
        if (full) begin
          drop_nxt = 1'b1;
        end else begin
          job.kind  = ilid_pkg::JOB_UP;
          job.ptr   = cnt_lo;
          count_nxt = count_r + 1'b1;
          priority if (idx_le0) begin
            job.stop = '0;
          end else if (idx_ge_cnt) begin
            job.stop = cnt_lo;
            pos_nxt  = PW'(count_r);
          end else begin
            job.stop = idx_lo;
            pos_nxt  = PW'(idx_lo);
          end
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (count_r != '0) begin
          job.kind  = ilid_pkg::JOB_DOWN;
          job.stop  = last_lo;
          count_nxt = count_r - 1'b1;
        end
        priority if (idx_le0) begin
          job.ptr = '0;
        end else if (idx_ge_last) begin
          job.ptr = last_lo;
          pos_nxt = (count_r == '0) ? '1 : PW'(count_r) - PW'(2);
        end else begin
          job.ptr = idx_lo;
          pos_nxt = PW'(idx_lo);
        end
      end
      ilid_pkg::OP_READ: begin
        if (in_index[15] || idx_ge_cnt) begin
          oor_nxt = 1'b1;
        end else begin
          job.kind = ilid_pkg::JOB_READ;
          job.ptr  = idx_lo;
          rd_nxt   = 1'b1;
        end
      end
      ilid_pkg::OP_NOP: begin
        job.kind = ilid_pkg::JOB_NONE;
      end
      default: begin
        job.kind = ilid_pkg::JOB_NONE;
      end
    endcase
  end

  ilid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .job      (job),
    .rd_data  (rd_data),
    .out_free (out_free),
    .mem_req  (mem_req),
    .busy     (busy),
    .finish   (finish)
  );

  ilid_mem u_mem (
    .clk       (clk),
    .req       (mem_req),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_pos_r  <= pos_nxt;
      res_drop_r <= drop_nxt;
      res_oor_r  <= oor_nxt;
      res_rd_r   <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_position_r    <= res_pos_r;
      out_entry_value_r <= res_rd_r ? rd_data : '0;
      out_entry_count_r <= count_r;
      out_dropped_r     <= res_drop_r;
      out_oor_r         <= res_oor_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_position     = out_position_r;
  assign out_entry_value  = out_entry_value_r;
  assign out_entry_count  = out_entry_count_r;
  assign out_dropped      = out_dropped_r;
  assign out_out_of_range = out_oor_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ilid_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + 1'b1) ||
               (count_r + 1'b1 == $past(count_r)))
    else $error("entry count moved by more than one");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dropped_r |-> out_entry_count_r == CW'(ilid_pkg::CAPACITY))
    else $error("insert dropped with room left");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_oor_r |-> out_entry_value_r == '0)
    else $error("out-of-range read returned data");

  a_no_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |-> busy)
    else $error("result produced with no item in work");
`endif

endmodule

`default_nettype wire

// File: verif/indexed_list_insert_delete_core_test.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_core_test
// Self-checking bench for the indexed list core. A short table of directed
// requests covers the empty list, the index extremes and the unused op code.
// Random fill, drain and mixed phases follow. Every result item is checked
// against its table row or a behavioural list model, with random idling on
// both channels, a long output hold-off and a pause until results drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_insert_delete_core_test;

  localparam int RAND_ITEMS  = 850;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 2 * ilid_pkg::CAPACITY + 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [7:0]  position;
    logic signed [31:0] entry_value;
    logic [6:0]         entry_count;
    logic               dropped;
    logic               out_of_range;
  } list_result_t;

  typedef struct {
    ilid_pkg::op_t      op;
    logic signed [31:0] value;
    logic signed [15:0] index;
    bit                 typed;
    list_result_t       res;
  } dir_row_t;

  typedef enum int {
    GEN_FILL,
    GEN_DRAIN,
    GEN_MIX
  } gen_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = ilid_pkg::OP_NOP;
  logic signed [31:0] in_value = '0;
  logic signed [15:0] in_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [7:0]  out_position;
  logic signed [31:0] out_entry_value;
  logic [6:0]         out_entry_count;
  logic               out_dropped;
  logic               out_out_of_range;

  logic signed [31:0] list_mem [ilid_pkg::CAPACITY];
  int                 list_cnt = 0;
  list_result_t       expected_q [$];
  dir_row_t           dir_rows [$];

  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit quiet = 1'b0;
  int n_by_op [4] = '{default: 0};
  int n_dropped = 0;
  int n_oor = 0;
  int n_full = 0;

  indexed_list_insert_delete_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .in_index         (in_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_position     (out_position),
    .out_entry_value  (out_entry_value),
    .out_entry_count  (out_entry_count),
    .out_dropped      (out_dropped),
    .out_out_of_range (out_out_of_range)
  );

  always #2 clk = ~clk;

  // list model: applies one request and returns its result item
  function automatic list_result_t apply_request(ilid_pkg::op_t op,
                                                 logic signed [31:0] val,
                                                 logic signed [15:0] idx);
    list_result_t r;
    int           i;
    int           p;
    r = '0;
    case (op)
      ilid_pkg::OP_INSERT: begin
        if (list_cnt >= ilid_pkg::CAPACITY) begin
          r.dropped = 1'b1;
        end else begin
          p = (idx <= 0) ? 0 : ((int'(idx) >= list_cnt) ? list_cnt : int'(idx));
          for (i = list_cnt; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_cnt++;
          r.position = p[7:0];
        end
      end
      ilid_pkg::OP_DELETE: begin
        if (idx <= 0) begin
          p = 0;
        end else if (int'(idx) >= list_cnt - 1) begin
          p = list_cnt - 1;
        end else begin
          p = int'(idx);
        end
        if (list_cnt > 0) begin
          if (p < 0) p = 0;
          for (i = p; i + 1 < list_cnt; i++) list_mem[i] = list_mem[i+1];
          list_cnt--;
        end
        r.position = (idx <= 0) ? 8'sd0 :
                     ((int'(idx) >= list_cnt) ? 8'(list_cnt - 1) : 8'(p));
      end
      ilid_pkg::OP_READ: begin
        if (idx < 0 || int'(idx) >= list_cnt) r.out_of_range = 1'b1;
        else r.entry_value = list_mem[int'(idx)];
      end
      default: ;
    endcase
    r.entry_count = list_cnt[6:0];
    return r;
  endfunction

  function automatic void add_dir_row(ilid_pkg::op_t op, logic signed [31:0] val,
                                      logic signed [15:0] idx, bit typed,
                                      logic signed [7:0] pos, logic [6:0] cnt,
                                      logic oor);
    dir_row_t row;
    row.op    = op;
    row.value = val;
    row.index = idx;
    row.typed = typed;
    row.res   = '{pos, 32'sd0, cnt, 1'b0, oor};
    dir_rows.push_back(row);
  endfunction

  function automatic logic signed [15:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 16'($urandom_range(0, list_cnt + 1));
    if (r < 80) begin
      case ($urandom_range(0, 3))
        0: return 16'sd0;
        1: return -16'sd1;
        2: return 16'(list_cnt - 1);
        default: return 16'(list_cnt);
      endcase
    end
    return 16'($urandom);
  endfunction

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 80) return 32'($urandom);
    case ($urandom_range(0, 3))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      default: return -32'sd1;
    endcase
  endfunction

  task automatic send_item(ilid_pkg::op_t op, logic signed [31:0] val,
                           logic signed [15:0] idx, bit typed,
                           list_result_t typed_res);
    list_result_t res;
    if (!quiet && $urandom_range(0, 99) < 10) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= val;
    in_index <= idx;
    do @(posedge clk); while (!in_ready);
    res = apply_request(op, val, idx);
    expected_q.push_back(typed ? typed_res : res);
    n_by_op[op]++;
    n_dropped += res.dropped;
    n_oor     += res.out_of_range;
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic flag_mismatch(string what, list_result_t want, list_result_t got);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $write("%s: expected pos=%0d val=%h cnt=%0d drop=%b oor=%b, ",
             what, want.position, want.entry_value, want.entry_count, want.dropped,
             want.out_of_range);
      $display("got pos=%0d val=%h cnt=%0d drop=%b oor=%b",
               got.position, got.entry_value, got.entry_count, got.dropped,
               got.out_of_range);
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(0, 99) >= 10);
    end
  end

  always @(posedge clk) begin
    list_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_position, out_entry_value, out_entry_count, out_dropped,
              out_out_of_range};
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected item", '0, got);
      end else if (got !== expected_q[0]) begin
        flag_mismatch("mismatch", expected_q[0], got);
        void'(expected_q.pop_front());
      end else begin
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    gen_mode_t          mode;
    int                 extra;
    int                 mix_left;
    int                 r;
    ilid_pkg::op_t      op;
    logic signed [15:0] idx;
    logic signed [31:0] val;

    // empty list
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        16'sd0,      1, 8'sd0,  7'd0, 1'b1);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd0,      1, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd7,      1, -8'sd1, 7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        -16'sd32768, 1, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd32767,  1, -8'sd1, 7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_NOP,    -32'sd1,       -16'sd1,     1, 8'sd0,  7'd0, 1'b0);
    // inserts at clamped and inner positions, then reads inside the entries
    add_dir_row(ilid_pkg::OP_INSERT, 32'sh7fffffff, 16'sd32767,  1, 8'sd0,  7'd1, 1'b0);
    add_dir_row(ilid_pkg::OP_INSERT, 32'sh80000000, -16'sd32768, 1, 8'sd0,  7'd2, 1'b0);
    add_dir_row(ilid_pkg::OP_INSERT, 32'sd0,        16'sd1,      1, 8'sd1,  7'd3, 1'b0);
    add_dir_row(ilid_pkg::OP_INSERT, -32'sd1,       16'sd3,      1, 8'sd3,  7'd4, 1'b0);
    add_dir_row(ilid_pkg::OP_INSERT, 32'sh12345678, 16'sd2,      0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_READ,   32'sh5a5a5a5a, 16'sd0,      0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        16'sd4,      0, 8'sd0,  7'd0, 1'b0);
    // reads outside the entries and a no-op
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        -16'sd1,     1, 8'sd0,  7'd5, 1'b1);
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        16'sd5,      1, 8'sd0,  7'd5, 1'b1);
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        16'sd32767,  1, 8'sd0,  7'd5, 1'b1);
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        -16'sd32768, 1, 8'sd0,  7'd5, 1'b1);
    add_dir_row(ilid_pkg::OP_NOP,    32'sh2468ace1, 16'sd4,      1, 8'sd0,  7'd5, 1'b0);
    // deletes at inner, back and front, and a read
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd2,      0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd32767,  0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        -16'sd5,     0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_READ,   32'sd0,        16'sd0,      0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd1,      0, 8'sd0,  7'd0, 1'b0);
    add_dir_row(ilid_pkg::OP_DELETE, 32'sd0,        16'sd0,      0, 8'sd0,  7'd0, 1'b0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].value, dir_rows[i].index,
                dir_rows[i].typed, dir_rows[i].res);
    wait_for_results();

    mode     = GEN_FILL;
    extra    = 0;
    mix_left = 0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      quiet = (k >= 300 && k < 450);
      if (k == 200) hold_req = 1'b1;
      if (k == 520) wait_for_results();
      r = $urandom_range(0, 99);
      case (mode)
        GEN_FILL:  op = (r < 75) ? ilid_pkg::OP_INSERT : (r < 85) ? ilid_pkg::OP_DELETE :
                        (r < 97) ? ilid_pkg::OP_READ : ilid_pkg::OP_NOP;
        GEN_DRAIN: op = (r < 10) ? ilid_pkg::OP_INSERT : (r < 75) ? ilid_pkg::OP_DELETE :
                        (r < 97) ? ilid_pkg::OP_READ : ilid_pkg::OP_NOP;
        default:   op = (r < 35) ? ilid_pkg::OP_INSERT : (r < 65) ? ilid_pkg::OP_DELETE :
                        (r < 95) ? ilid_pkg::OP_READ : ilid_pkg::OP_NOP;
      endcase
      idx = pick_index();
      val = pick_value();
      send_item(op, val, idx, 0, '0);
      case (mode)
        GEN_FILL: begin
          if (list_cnt == ilid_pkg::CAPACITY) extra++;
          if (extra >= 5) begin
            n_full++;
            mode  = GEN_DRAIN;
            extra = 0;
          end
        end
        GEN_DRAIN: begin
          if (list_cnt == 0) extra++;
          if (extra >= 3) begin
            mode     = GEN_MIX;
            mix_left = 80;
            extra    = 0;
          end
        end
        default: begin
          mix_left--;
          if (mix_left == 0) mode = GEN_FILL;
        end
      endcase
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) errors++;
    $display("requests: %0d insert, %0d delete, %0d read, %0d unused op",
             n_by_op[ilid_pkg::OP_INSERT], n_by_op[ilid_pkg::OP_DELETE],
             n_by_op[ilid_pkg::OP_READ], n_by_op[ilid_pkg::OP_NOP]);
    $display("list filled %0d times, %0d inserts refused at full, %0d reads outside, %0d errors",
             n_full, n_dropped, n_oor, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ilid_pkg.sv
hw/rtl/ilid_mem.sv
hw/rtl/ilid_ctrl.sv
hw/rtl/indexed_list_insert_delete_core.sv
verif/indexed_list_insert_delete_core_test.sv
